>>> rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and the rotate function for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned RoundW  = 6;
  localparam int unsigned BlkBytes = 64;
  localparam int unsigned PadLimit = 56;

  typedef logic [WordW-1:0] word_t;
  typedef logic [RoundW-1:0] rnd_t;

  typedef enum logic [1:0] {
    LD_BYTE = 2'd0,
    LD_PAD  = 2'd1,
    LD_ZERO = 2'd2,
    LD_LEN  = 2'd3
  } load_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic      load;      // write one byte into the block window
    load_sel_t load_sel;
    logic      add_bits;  // add current byte count * 8 to length
    logic      blk_bits;  // add 512 to length
    logic      start;     // begin compression
    logic      init;      // reload initial hash, clear counters
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;
    logic [RoundW-1:0] byte_cnt;
  } dp_stat_t;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

>>> rtl/sha256_dp.sv
// ----------------------------------------------------------------------------
// sha256_dp
// Datapath: 16-word schedule window, working registers, one round per cycle.
// ----------------------------------------------------------------------------
module sha256_dp
  import sha256_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  dp_cmd_t       cmd,
  input  logic [7:0]    byte_in,
  output dp_stat_t      stat,
  output logic [255:0]  digest
);

  word_t       blk_r [16];
  word_t       blk_nxt [16];
  word_t       w_r [16];
  word_t       h_r [8];
  word_t       v_r [8];
  logic [RoundW-1:0] cnt_r;
  logic [63:0] bits_r;
  logic        busy_r;
  logic        fin_r;
  rnd_t        rnd_r;
  logic [7:0]  ld_byte;
  word_t       s0, s1, wnew, t1, t2, e, a;

  always_comb begin
    unique case (cmd.load_sel)
      LD_BYTE: ld_byte = byte_in;
      LD_PAD:  ld_byte = 8'h80;
      LD_ZERO: ld_byte = 8'h00;
      LD_LEN:  ld_byte = bits_r[8*(7-cnt_r[2:0]) +: 8];
      default: ld_byte = 8'h00;
    endcase
  end

  // byte written this cycle is visible to a compression started this cycle
  always_comb begin
    blk_nxt = blk_r;
    if (cmd.load) blk_nxt[cnt_r[5:2]][{~cnt_r[1:0], 3'b000} +: 8] = ld_byte;
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  assign s0   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wnew = s1 + w_r[9] + s0 + w_r[0];
  assign e    = v_r[4];
  assign a    = v_r[0];
  assign t1   = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & v_r[5]) ^ (~e & v_r[6])) + RoundK[rnd_r] + w_r[0];
  assign t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
      bits_r <= '0;
      rnd_r  <= '0;
      h_r    <= InitH;
    end else begin
      fin_r <= 1'b0;
      if (cmd.init) begin
        h_r    <= InitH;
        cnt_r  <= '0;
        bits_r <= '0;
      end
      if (cmd.add_bits) bits_r <= bits_r + {55'd0, cnt_r, 3'd0};
      if (cmd.blk_bits) bits_r <= bits_r + 64'd512;
      if (cmd.load) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        v_r    <= h_r;
        for (int i = 0; i < 16; i++) begin
          w_r[i] <= blk_nxt[i];
        end
      end else if (busy_r) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wnew;
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
        rnd_r  <= rnd_r + 1'b1;
        if (rnd_r == RoundW'(Rounds - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  assign stat.busy     = busy_r | fin_r;
  assign stat.byte_cnt = cnt_r;
  assign digest = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4], h_r[5], h_r[6], h_r[7]};

  property p_start_idle;
    @(posedge clk) disable iff (!rst_n) cmd.start |-> !busy_r && !fin_r;
  endproperty
  assert property (p_start_idle) else $error("start while compressing");

  property p_fin_after_busy;
    @(posedge clk) disable iff (!rst_n) fin_r |-> $past(busy_r);
  endproperty
  assert property (p_fin_after_busy) else $error("finish without rounds");

  property p_no_load_busy;
    @(posedge clk) disable iff (!rst_n) cmd.load |-> !busy_r;
  endproperty
  assert property (p_no_load_busy) else $error("buffer write during rounds");

endmodule

>>> rtl/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// sha256_ctrl
// Controller: byte intake, padding sequence, compression launch, digest out.
// ----------------------------------------------------------------------------
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     byte_valid,
  input  logic     last_item,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     out_tvalid,
  input  logic     out_tready,
  output logic     cap
);

  typedef enum logic [3:0] {
    S_IDLE, S_BLKWAIT, S_PADSTART, S_PAD, S_ZERO1, S_WAIT1, S_ZERO2,
    S_LEN, S_WAIT2, S_OUT, S_WAITP
  } state_t;

  state_t state_r;
  logic   last_r;
  logic   out_valid_r;
  logic   acc;

  assign in_tready  = (state_r == S_IDLE) && !stat.busy;
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd = '0;
    cap = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc && byte_valid) begin
          cmd.load = 1'b1;
          cmd.load_sel = LD_BYTE;
        end
      end
      S_BLKWAIT: begin
        cmd.start = 1'b1;
        cmd.blk_bits = 1'b1;
      end
      S_PADSTART: cmd.add_bits = 1'b1;
      S_PAD: begin
        cmd.load = 1'b1;
        cmd.load_sel = LD_PAD;
        if (stat.byte_cnt == RoundW'(BlkBytes - 1)) cmd.start = 1'b1;
      end
      S_ZERO1: begin
        cmd.load = 1'b1;
        cmd.load_sel = LD_ZERO;
        if (stat.byte_cnt == RoundW'(BlkBytes - 1)) cmd.start = 1'b1;
      end
      S_ZERO2: begin
        cmd.load = 1'b1;
        cmd.load_sel = LD_ZERO;
      end
      S_LEN: begin
        cmd.load = 1'b1;
        cmd.load_sel = LD_LEN;
        if (stat.byte_cnt == RoundW'(BlkBytes - 1)) cmd.start = 1'b1;
      end
      S_WAIT2: begin
        if (!stat.busy) cap = 1'b1;
      end
      S_OUT: begin
        if (out_tready) cmd.init = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            last_r <= last_item;
            if (byte_valid && stat.byte_cnt == RoundW'(BlkBytes - 1))
              state_r <= S_BLKWAIT;
            else if (last_item)
              state_r <= S_PADSTART;
          end
        end
        S_BLKWAIT: state_r <= S_WAIT1;
        S_WAIT1: begin
          if (!stat.busy) begin
            if (last_r) begin
              state_r <= S_PADSTART;
              last_r  <= 1'b0;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_PADSTART: state_r <= S_PAD;
        S_PAD: begin
          if (stat.byte_cnt == RoundW'(BlkBytes - 1)) state_r <= S_WAITP;
          else if (stat.byte_cnt == RoundW'(PadLimit - 1)) state_r <= S_LEN;
          else if (stat.byte_cnt > RoundW'(PadLimit - 1)) state_r <= S_ZERO1;
          else state_r <= S_ZERO2;
        end
        S_ZERO1: begin
          if (stat.byte_cnt == RoundW'(BlkBytes - 1)) state_r <= S_WAITP;
        end
        S_WAITP: begin
          if (!stat.busy) state_r <= S_ZERO2;
        end
        S_ZERO2: begin
          if (stat.byte_cnt == RoundW'(PadLimit - 1)) state_r <= S_LEN;
        end
        S_LEN: begin
          if (stat.byte_cnt == RoundW'(BlkBytes - 1)) state_r <= S_WAIT2;
        end
        S_WAIT2: begin
          if (!stat.busy) begin
            state_r     <= S_OUT;
            out_valid_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  property p_out_only_in_out;
    @(posedge clk) disable iff (!rst_n) out_valid_r |-> state_r == S_OUT;
  endproperty
  assert property (p_out_only_in_out) else $error("result valid outside output");

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) acc |-> !stat.busy;
  endproperty
  assert property (p_no_accept_busy) else $error("accept while compressing");

  property p_len_ends_block;
    @(posedge clk) disable iff (!rst_n)
      (state_r == S_LEN && stat.byte_cnt == RoundW'(BlkBytes - 1)) |-> cmd.start;
  endproperty
  assert property (p_len_ends_block) else $error("final block not launched");

endmodule

>>> rtl/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 over a byte stream with streaming input and digest output.
// ----------------------------------------------------------------------------
// One byte is taken per transaction; a byte that does not fill a block leaves
// the input ready for the next. The 64th byte of a block starts the compression,
// which runs one round per cycle, and the next transaction is not taken until
// it is done. A last transaction pads through the byte write port of the block
// window (one byte per cycle, pausing while a compression runs) and runs one or
// two more compressions before the digest is presented; the digest register
// holds until the result transaction completes.
module sha256_stream_hasher_core
  import sha256_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] byte_valid
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata   // [63:0] digest_part0 .. [255:192] digest_part3
);

  dp_cmd_t      cmd;
  dp_stat_t     stat;
  logic [255:0] digest;
  logic [255:0] dig_r;
  logic         cap;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .byte_valid (in_tuser),
    .last_item  (in_tlast),
    .stat       (stat),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cap        (cap)
  );

  sha256_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .byte_in (in_tdata),
    .stat    (stat),
    .digest  (digest)
  );

  always_ff @(posedge clk) begin
    if (cap) dig_r <= digest;
  end

  assign out_tdata = {dig_r[63:0], dig_r[127:64], dig_r[191:128], dig_r[255:192]};

endmodule

>>> dv/sha256_stream_hasher_core_tb.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core_tb
// Streams byte messages of varied length into the hasher and checks each
// digest against a behavioral SHA-256 model kept in the testbench.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core_tb;
  import sha256_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_item;
  } msg_item_t;

  typedef struct packed {
    logic [63:0] digest_part0;
    logic [63:0] digest_part1;
    logic [63:0] digest_part2;
    logic [63:0] digest_part3;
  } digest_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [255:0] out_tdata;

  msg_item_t   pending_items[$];
  digest_t     expected_digests[$];
  word_t       chain_h[8];
  logic [7:0]  blk_buf[64];
  int unsigned blk_fill;
  logic [63:0] msg_bits;
  int          n_fail;
  bit          hold_done;
  bit          sender_hold;
  bit          no_idle;
  int          rx_hold_cycles;
  bit          rx_hold_req;
  bit          in_fire;

  sha256_stream_hasher_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic word_t ror32(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_buf();
    word_t w[64];
    word_t v[8];
    word_t t1, t2, s0, s1;
    for (int r = 0; r < 16; r++)
      w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
    for (int r = 16; r < 64; r++) begin
      s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = s1 + w[r-7] + s0 + w[r-16];
    end
    for (int r = 0; r < 8; r++) v[r] = chain_h[r];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int r = 0; r < 8; r++) chain_h[r] += v[r];
  endtask

  task automatic restart_msg();
    for (int i = 0; i < 8; i++) chain_h[i] = InitH[i];
    blk_fill = 0;
    msg_bits = '0;
  endtask

  task automatic hash_item(msg_item_t it);
    int unsigned i;
    digest_t d;
    if (it.byte_valid) begin
      blk_buf[blk_fill] = it.data_byte;
      blk_fill++;
      if (blk_fill == 64) begin
        compress_buf();
        msg_bits += 64'd512;
        blk_fill = 0;
      end
    end
    if (it.last_item) begin
      i = blk_fill;
      msg_bits += 64'(i) * 64'd8;
      blk_buf[i] = 8'h80;
      i++;
      if (i > 56) begin
        while (i < 64) begin blk_buf[i] = 8'h00; i++; end
        compress_buf();
        i = 0;
      end
      while (i < 56) begin blk_buf[i] = 8'h00; i++; end
      for (int k = 0; k < 8; k++) blk_buf[63-k] = msg_bits[8*k +: 8];
      compress_buf();
      d.digest_part0 = {chain_h[0], chain_h[1]};
      d.digest_part1 = {chain_h[2], chain_h[3]};
      d.digest_part2 = {chain_h[4], chain_h[5]};
      d.digest_part3 = {chain_h[6], chain_h[7]};
      expected_digests.push_back(d);
      restart_msg();
    end
  endtask

  task automatic push_item(logic [7:0] b, logic v, logic l);
    msg_item_t it;
    it.data_byte = b;
    it.byte_valid = v;
    it.last_item = l;
    pending_items.push_back(it);
  endtask

  task automatic push_msg(int len, bit last_on_byte);
    for (int i = 0; i < len; i++)
      push_item(8'($urandom), 1'b1, last_on_byte && (i == len - 1));
    if (!last_on_byte || len == 0) push_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // hold the offered transaction
    end else if (pending_items.size() != 0 && !sender_hold
                 && (no_idle || $urandom_range(99) >= 29)) begin
      in_tvalid <= 1'b1;
      in_tdata  <= pending_items[0].data_byte;
      in_tuser  <= pending_items[0].byte_valid;
      in_tlast  <= pending_items[0].last_item;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) begin
      hash_item(pending_items.pop_front());
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_req && rx_hold_cycles == 0) begin
      rx_hold_cycles <= 3000;
      out_tready <= 1'b0;
    end else if (rx_hold_cycles > 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
      out_tready <= (rx_hold_cycles == 1);
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 29);
    end
  end

  // monitor
  always @(posedge clk) begin
    digest_t act, exp_d;
    if (rst_n && out_tvalid && out_tready) begin
      act.digest_part0 = out_tdata[63:0];
      act.digest_part1 = out_tdata[127:64];
      act.digest_part2 = out_tdata[191:128];
      act.digest_part3 = out_tdata[255:192];
      if (expected_digests.size() == 0) begin
        $error("unexpected digest transaction %h", out_tdata);
        n_fail++;
      end else begin
        exp_d = expected_digests.pop_front();
        if (act.digest_part0 !== exp_d.digest_part0) begin
          $error("digest_part0 exp %h act %h", exp_d.digest_part0, act.digest_part0);
          n_fail++;
        end
        if (act.digest_part1 !== exp_d.digest_part1) begin
          $error("digest_part1 exp %h act %h", exp_d.digest_part1, act.digest_part1);
          n_fail++;
        end
        if (act.digest_part2 !== exp_d.digest_part2) begin
          $error("digest_part2 exp %h act %h", exp_d.digest_part2, act.digest_part2);
          n_fail++;
        end
        if (act.digest_part3 !== exp_d.digest_part3) begin
          $error("digest_part3 exp %h act %h", exp_d.digest_part3, act.digest_part3);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #30000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int n;
    int len;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    in_fire = 1'b0;
    out_tready = 1'b0;
    n_fail = 0;
    hold_done = 0;
    sender_hold = 0;
    no_idle = 0;
    rx_hold_cycles = 0;
    rx_hold_req = 0;
    for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
    restart_msg();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty, noise, boundary lengths, byte extremes
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    push_msg(55, 1);
    push_msg(56, 1);
    push_msg(64, 0);
    push_msg(63, 0);
    wait (pending_items.size() == 0 && expected_digests.size() == 0);

    // receiver stall while the sender keeps offering
    rx_hold_req = 1;
    push_msg(3, 1);
    push_msg(1, 0);
    push_msg(2, 1);
    push_msg(5, 1);
    repeat (10) @(posedge clk);
    rx_hold_req = 0;
    wait (pending_items.size() == 0 && expected_digests.size() == 0);

    n = 0;
    while (n < 1000) begin
      if (n > 400 && n < 700) no_idle = 1; else no_idle = 0;
      case ($urandom_range(9))
        0: len = $urandom_range(130, 54);
        1: len = 64 * $urandom_range(2, 1);
        default: len = $urandom_range(20);
      endcase
      if ($urandom_range(4) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      push_msg(len, $urandom_range(1));
      n += len + 1;
      if ($urandom_range(15) == 0 || !hold_done) begin
        hold_done = 1;
        sender_hold = 1;
        wait (pending_items.size() == 0 || expected_digests.size() == 0);
        wait (expected_digests.size() == 0 && !in_tvalid);
        sender_hold = 0;
      end
      wait (pending_items.size() < 40);
    end
    wait (pending_items.size() == 0 && expected_digests.size() == 0);
    repeat (300) @(posedge clk);
    if (n_fail == 0 && expected_digests.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sha256_stream_hasher_core.f
rtl/sha256_pkg.sv
rtl/sha256_dp.sv
rtl/sha256_ctrl.sv
rtl/sha256_stream_hasher_core.sv
dv/sha256_stream_hasher_core_tb.sv
